// File: rtl/tgrls_pkg.sv
// shared types and constants for the thrust gain estimator
// used by every rtl file; depends on nothing
`default_nettype none
package tgrls_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_NUM_W = 80;
  localparam int DIV_DEN_W = 57;

  localparam logic [1:0] FUNC_PUSH     = 2'd0;
  localparam logic [1:0] FUNC_ESTIMATE = 2'd1;
  localparam logic [1:0] FUNC_RESET    = 2'd2;

  localparam logic [2:0] REG_FORGET   = 3'd0;
  localparam logic [2:0] REG_INIT_G   = 3'd1;
  localparam logic [2:0] REG_INIT_P   = 3'd2;
  localparam logic [2:0] REG_MAX_AGE  = 3'd3;
  localparam logic [2:0] REG_MIN_AGE  = 3'd4;

  localparam logic [17:0] FORGET_RST  = 18'd65405;
  localparam logic [22:0] INIT_G_RST  = 23'd989086;
  localparam logic [23:0] INIT_P_RST  = 24'd1000000;
  localparam logic [19:0] MAX_AGE_RST = 20'd45000;
  localparam logic [19:0] MIN_AGE_RST = 20'd35000;

  localparam logic [22:0] GAIN_MAX = 23'h7FFFFF;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        time_us;
    logic [15:0]        throttle;
    logic signed [23:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic        updated;
    logic        dropped;
    logic [22:0] gain;
  } out_item_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [31:0] wr_time;
    logic [15:0] wr_thr;
  } fifo_ctrl_t;

  typedef struct packed {
    logic [CW-1:0] count;
    logic          full;
    logic          empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

// File: rtl/thrust_gain_rls_estimator.sv
// push and reset items: result loaded in S_DONE once the output register is free
// estimate: S_READ and S_CHECK for each queued entry looked at, then for an update
// the multiply states and two 80-step passes through the one-bit-per-cycle divider
// one item at a time: in_ready is low from transfer until the result is loaded
// rst (synchronous) empties the queue, loads register defaults, gain and covariance
`default_nettype none
module thrust_gain_rls_estimator (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tgrls_pkg::in_item_t in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tgrls_pkg::out_item_t     out_data,
  input  wire logic                cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [23:0]         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CHECK, S_MUL_TP, S_MUL_T2P, S_MUL_TG,
    S_DIV_K, S_MUL_KE, S_UPD_G, S_DIV_P, S_DONE
  } state_t;

  state_t state;

  logic [17:0] forget_factor;
  logic [22:0] initial_gain;
  logic [23:0] initial_covariance;
  logic [19:0] max_age_us;
  logic [19:0] min_age_us;

  logic [22:0]        gain;
  logic [47:0]        cov;
  logic [31:0]        now;
  logic signed [23:0] accel;
  logic [15:0]        thr;
  logic [63:0]        tp;
  logic [63:0]        t2p;
  logic signed [25:0] err;
  logic [39:0]        kf;
  logic [40:0]        delta;
  logic               updated;
  logic               dropped;

  tgrls_pkg::fifo_ctrl_t fctrl;
  tgrls_pkg::fifo_stat_t fstat;
  logic [31:0] rd_time;
  logic [15:0] rd_thr;

  logic                               div_start;
  logic [tgrls_pkg::DIV_NUM_W-1:0]    div_num;
  logic [tgrls_pkg::DIV_DEN_W-1:0]    div_den;
  logic                               div_done;
  logic [tgrls_pkg::DIV_NUM_W-1:0]    div_quo;

  logic [17:0] rho;
  logic [31:0] age;
  logic        future;
  logic        too_old;
  logic        too_young;
  logic [79:0] t2p_prod;
  logic [38:0] tg_prod;
  logic [24:0] mag;
  logic [64:0] ke_prod;
  logic signed [42:0] g_sum;
  logic        accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    rho       = (forget_factor == '0) ? 18'd1 : forget_factor;
    age       = now - rd_time;
    future    = age[31];
    too_old   = !future && (age > {12'd0, max_age_us});
    too_young = future || (age < {12'd0, min_age_us});
    t2p_prod  = 80'(tp) * 80'(thr);
    tg_prod   = 39'(thr) * 39'(gain);
    mag       = err[25] ? 25'(-err) : 25'(err);
    ke_prod   = 65'(kf) * 65'(mag);
    if (err[25]) begin
      g_sum = $signed({20'd0, gain}) - $signed({2'd0, delta});
    end else begin
      g_sum = $signed({20'd0, gain}) + $signed({2'd0, delta});
    end
  end

  always_comb begin
    fctrl.push    = accept && (in_data.func == tgrls_pkg::FUNC_PUSH) && !fstat.full;
    fctrl.pop     = (state == S_CHECK) && (too_old || !too_young);
    fctrl.wr_time = in_data.time_us;
    fctrl.wr_thr  = in_data.throttle;
  end

  // divider starts when the numerator of each quotient is ready
  always_comb begin
    div_start = (state == S_MUL_TG) || (state == S_UPD_G);
    div_den   = {23'd0, rho, 16'd0} + {1'b0, t2p[63:8]};
    if (state == S_UPD_G) begin
      div_num = {cov, 32'd0};
    end else begin
      div_num = {tp, 16'd0};
    end
  end

  tgrls_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (fctrl),
    .stat    (fstat),
    .rd_time (rd_time),
    .rd_thr  (rd_thr)
  );

  tgrls_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      forget_factor      <= tgrls_pkg::FORGET_RST;
      initial_gain       <= tgrls_pkg::INIT_G_RST;
      initial_covariance <= tgrls_pkg::INIT_P_RST;
      max_age_us         <= tgrls_pkg::MAX_AGE_RST;
      min_age_us         <= tgrls_pkg::MIN_AGE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tgrls_pkg::REG_FORGET:  forget_factor      <= cfg_data[17:0];
        tgrls_pkg::REG_INIT_G:  initial_gain       <= cfg_data[22:0];
        tgrls_pkg::REG_INIT_P:  initial_covariance <= cfg_data;
        tgrls_pkg::REG_MAX_AGE: max_age_us         <= cfg_data[19:0];
        tgrls_pkg::REG_MIN_AGE: min_age_us         <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      gain      <= tgrls_pkg::INIT_G_RST;
      cov       <= {tgrls_pkg::INIT_P_RST, 24'd0};
    end else begin
      // in S_DONE the load below decides out_valid
      if (out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            now     <= in_data.time_us;
            accel   <= in_data.accel_z;
            updated <= 1'b0;
            dropped <= 1'b0;
            state   <= S_DONE;
            priority case (in_data.func)
              tgrls_pkg::FUNC_PUSH: begin
                dropped <= fstat.full;
              end
              tgrls_pkg::FUNC_ESTIMATE: begin
                state <= S_READ;
              end
              tgrls_pkg::FUNC_RESET: begin
                gain <= initial_gain;
                cov  <= {initial_covariance, 24'd0};
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          // head entry shows up on the registered read next cycle
          state <= fstat.empty ? S_DONE : S_CHECK;
        end
        S_CHECK: begin
          if (too_old) begin
            state <= S_READ;
          end else if (too_young) begin
            state <= S_DONE;
          end else begin
            thr   <= rd_thr;
            state <= S_MUL_TP;
          end
        end
        S_MUL_TP: begin
          tp    <= 64'(cov) * 64'(thr);
          state <= S_MUL_T2P;
        end
        S_MUL_T2P: begin
          t2p   <= t2p_prod[79:16];
          state <= S_MUL_TG;
        end
        S_MUL_TG: begin
          err   <= {{2{accel[23]}}, accel} - $signed({3'd0, tg_prod[38:16]});
          state <= S_DIV_K;
        end
        S_DIV_K: begin
          if (div_done) begin
            kf    <= (div_quo[79:40] != '0) ? '1 : div_quo[39:0];
            state <= S_MUL_KE;
          end
        end
        S_MUL_KE: begin
          delta <= ke_prod[64:24];
          state <= S_UPD_G;
        end
        S_UPD_G: begin
          if (g_sum[42]) begin
            gain <= '0;
          end else if (g_sum > $signed({20'd0, tgrls_pkg::GAIN_MAX})) begin
            gain <= tgrls_pkg::GAIN_MAX;
          end else begin
            gain <= g_sum[22:0];
          end
          state <= S_DIV_P;
        end
        S_DIV_P: begin
          if (div_done) begin
            cov     <= (div_quo[79:48] != '0) ? '1 : div_quo[47:0];
            updated <= 1'b1;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            out_data.updated <= updated;
            out_data.dropped <= dropped;
            out_data.gain    <= gain;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/tgrls_fifo.sv
// sample queue: time and throttle store with head pointer and fill count
// depends on tgrls_pkg
`default_nettype none
module tgrls_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tgrls_pkg::fifo_ctrl_t ctrl,
  output tgrls_pkg::fifo_stat_t      stat,
  output logic [31:0]                rd_time,
  output logic [15:0]                rd_thr
);

  logic [31:0] times [tgrls_pkg::QUEUE_DEPTH];
  logic [15:0] thrs  [tgrls_pkg::QUEUE_DEPTH];
  logic [tgrls_pkg::QW-1:0] head;
  logic [tgrls_pkg::CW-1:0] count;
  logic [tgrls_pkg::CW:0]   tail_sum;
  logic [tgrls_pkg::CW:0]   tail_wrap;
  logic [tgrls_pkg::QW-1:0] tail;

  always_comb begin
    tail_sum = (tgrls_pkg::CW+1)'(head) + (tgrls_pkg::CW+1)'(count);
    if (tail_sum >= (tgrls_pkg::CW+1)'(tgrls_pkg::QUEUE_DEPTH)) begin
      tail_wrap = tail_sum - (tgrls_pkg::CW+1)'(tgrls_pkg::QUEUE_DEPTH);
    end else begin
      tail_wrap = tail_sum;
    end
    tail = tail_wrap[tgrls_pkg::QW-1:0];
  end

  assign stat.count = count;
  assign stat.full  = (count == tgrls_pkg::CW'(tgrls_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      times[tail] <= ctrl.wr_time;
      thrs[tail]  <= ctrl.wr_thr;
    end
    rd_time <= times[head];
    rd_thr  <= thrs[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctrl.pop) begin
      if (head == tgrls_pkg::QW'(tgrls_pkg::QUEUE_DEPTH - 1)) begin
        head <= '0;
      end else begin
        head <= head + 1'b1;
      end
      count <= count - 1'b1;
    end else if (ctrl.push) begin
      count <= count + 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tgrls_div.sv
// restoring divider, one quotient bit per cycle, shared by gain factor and covariance
// depends on tgrls_pkg
`default_nettype none
module tgrls_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [tgrls_pkg::DIV_NUM_W-1:0]   num,
  input  wire logic [tgrls_pkg::DIV_DEN_W-1:0]   den,
  output logic                                   done,
  output logic [tgrls_pkg::DIV_NUM_W-1:0]        quo
);

  localparam int NW = tgrls_pkg::DIV_NUM_W;
  localparam int DW = tgrls_pkg::DIV_DEN_W;
  localparam int SW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [SW-1:0] steps;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial = {rem, quo[NW-1]};
    diff  = trial - {1'b0, dvs};
    ge    = !diff[DW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SW'(NW);
        rem   <= '0;
        dvs   <= den;
        quo   <= num;
      end else if (busy) begin
        rem   <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo   <= {quo[NW-2:0], ge};
        steps <= steps - 1'b1;
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/tgrls_checker.sv
// port-level checks for the thrust gain estimator, bound to the top level
// depends on tgrls_pkg
`default_nettype none
module tgrls_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire tgrls_pkg::out_item_t out_data
);

  // a result waiting for transfer holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("reset did not clear result or ready");

  // one item in flight: ready drops after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.updated && out_data.dropped))
    else $error("updated and dropped both set");

endmodule

bind thrust_gain_rls_estimator tgrls_checker u_tgrls_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: tb/thrust_gain_rls_estimator_test.sv
// testbench for the thrust gain rls estimator: random and directed items, own gain predictor
// depends on tgrls_pkg and thrust_gain_rls_estimator
module thrust_gain_rls_estimator_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tgrls_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tgrls_pkg::out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  thrust_gain_rls_estimator dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #6 clk = ~clk;

  // predictor state
  logic [31:0] fifo_time [tgrls_pkg::QUEUE_DEPTH];
  logic [15:0] fifo_thr [tgrls_pkg::QUEUE_DEPTH];
  int unsigned fifo_head, fifo_count;
  logic [22:0] gain_est;
  logic [47:0] cov_est;
  logic [17:0] rho_reg;
  logic [22:0] init_gain_reg;
  logic [23:0] init_cov_reg;
  logic [19:0] max_age_reg, min_age_reg;

  tgrls_pkg::in_item_t pending_items[$];
  tgrls_pkg::out_item_t expected_results[$];
  int errors = 0;
  int n_updates = 0, n_drops = 0, n_results = 0;
  logic [31:0] clock_us;

  function automatic logic [47:0] sat_div(logic [127:0] num, logic [63:0] den,
                                          logic [47:0] maxq);
    logic [127:0] q;
    q = num / den;
    return (q > maxq) ? maxq : q[47:0];
  endfunction

  function automatic void rls_step(logic [15:0] t, logic signed [23:0] a);
    logic [63:0] rho, tp, t2p, d, k, mag, delta;
    logic signed [63:0] e, g;
    rho = (rho_reg == 0) ? 64'd1 : 64'(rho_reg);
    tp = 64'(cov_est) * t;
    t2p = 64'((80'(tp) * 80'(t)) >> 16);
    d = (rho << 16) + (t2p >> 8);
    k = 64'(sat_div({64'd0, tp} << 16, d, 48'hFF_FFFF_FFFF));
    e = 64'(a) - $signed(64'((64'(t) * gain_est) >> 16));
    mag = (e < 0) ? -e : e;
    delta = (k * mag) >> 24;
    g = $signed(64'(gain_est)) + ((e < 0) ? -$signed(delta) : $signed(delta));
    if (g < 0) g = 0;
    if (g > 64'(tgrls_pkg::GAIN_MAX)) g = 64'(tgrls_pkg::GAIN_MAX);
    gain_est = g[22:0];
    cov_est = sat_div({80'd0, cov_est} << 32, d, 48'hFFFF_FFFF_FFFF);
  endfunction

  function automatic logic try_estimate(logic [31:0] now, logic signed [23:0] a);
    logic [31:0] age;
    logic future;
    while (fifo_count > 0) begin
      age = now - fifo_time[fifo_head];
      future = age[31];
      if (!future && age > max_age_reg) begin
        fifo_head = (fifo_head + 1) % tgrls_pkg::QUEUE_DEPTH;
        fifo_count--;
        continue;
      end
      if (future || age < min_age_reg) return 1'b0;
      rls_step(fifo_thr[fifo_head], a);
      fifo_head = (fifo_head + 1) % tgrls_pkg::QUEUE_DEPTH;
      fifo_count--;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic tgrls_pkg::out_item_t predict_result(tgrls_pkg::in_item_t it);
    tgrls_pkg::out_item_t r;
    r = '0;
    case (it.func)
      tgrls_pkg::FUNC_PUSH: begin
        if (fifo_count >= tgrls_pkg::QUEUE_DEPTH) r.dropped = 1'b1;
        else begin
          fifo_time[(fifo_head + fifo_count) % tgrls_pkg::QUEUE_DEPTH] = it.time_us;
          fifo_thr[(fifo_head + fifo_count) % tgrls_pkg::QUEUE_DEPTH] = it.throttle;
          fifo_count++;
        end
      end
      tgrls_pkg::FUNC_ESTIMATE: r.updated = try_estimate(it.time_us, it.accel_z);
      tgrls_pkg::FUNC_RESET: begin
        gain_est = init_gain_reg;
        cov_est = {init_cov_reg, 24'd0};
      end
      default: ;
    endcase
    r.gain = gain_est;
    return r;
  endfunction

  // driver
  logic [7:0] in_gap = 0;
  logic hold_in = 1'b0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results = {expected_results, predict_result(in_data)};
        if (pending_items.size() > 0 && !hold_in && $urandom_range(0, 3) != 0) begin
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_gap <= ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 60))
                                                 : 8'($urandom_range(0, 3));
        end
      end else if (!in_valid) begin
        if (in_gap != 0) in_gap <= in_gap - 8'd1;
        else if (pending_items.size() > 0 && !hold_in) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          tgrls_pkg::out_item_t exp_r;
          exp_r = expected_results.pop_front();
          n_results++;
          if (exp_r.updated) n_updates++;
          if (exp_r.dropped) n_drops++;
          if (out_data.updated !== exp_r.updated) begin
            $error("updated: expected %0d actual %0d", exp_r.updated, out_data.updated);
            errors++;
          end
          if (out_data.dropped !== exp_r.dropped) begin
            $error("dropped: expected %0d actual %0d", exp_r.dropped, out_data.dropped);
            errors++;
          end
          if (out_data.gain !== exp_r.gain) begin
            $error("gain: expected %0d actual %0d", exp_r.gain, out_data.gain);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      tgrls_pkg::REG_FORGET: rho_reg = val[17:0];
      tgrls_pkg::REG_INIT_G: init_gain_reg = val[22:0];
      tgrls_pkg::REG_INIT_P: init_cov_reg = val;
      tgrls_pkg::REG_MAX_AGE: max_age_reg = val[19:0];
      tgrls_pkg::REG_MIN_AGE: min_age_reg = val[19:0];
      default: ;
    endcase
  endtask

  function automatic tgrls_pkg::in_item_t make_item(logic [1:0] f, logic [31:0] t,
                                                    logic [15:0] thr, logic [23:0] a);
    tgrls_pkg::in_item_t it;
    it.func = f;
    it.time_us = t;
    it.throttle = thr;
    it.accel_z = a;
    return it;
  endfunction

  task automatic add_item(logic [1:0] f, logic [31:0] t, logic [15:0] thr, logic [23:0] a);
    pending_items = {pending_items, make_item(f, t, thr, a)};
  endtask

  // random flight: a mix of pushes, estimates, resets and the unused code, time advanced by random steps
  task automatic queue_flight(int n);
    int k;
    logic [1:0] f;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0: f = tgrls_pkg::FUNC_RESET;
        1: f = 2'd3;
        2, 3, 4, 5, 6, 7, 8, 9: f = tgrls_pkg::FUNC_PUSH;
        default: f = tgrls_pkg::FUNC_ESTIMATE;
      endcase
      clock_us += ($urandom_range(0, 30) == 0) ? $urandom() : $urandom_range(0, 12000);
      add_item(f, clock_us, 16'($urandom()),
               24'(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1600000)));
    end
  endtask

  initial begin
    int k;
    fifo_head = 0;
    fifo_count = 0;
    rho_reg = tgrls_pkg::FORGET_RST;
    init_gain_reg = tgrls_pkg::INIT_G_RST;
    init_cov_reg = tgrls_pkg::INIT_P_RST;
    max_age_reg = tgrls_pkg::MAX_AGE_RST;
    min_age_reg = tgrls_pkg::MIN_AGE_RST;
    gain_est = tgrls_pkg::INIT_G_RST;
    cov_est = {tgrls_pkg::INIT_P_RST, 24'd0};
    clock_us = $urandom();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fill to overflow, extremes, future sample, empty queue, unused code
    add_item(tgrls_pkg::FUNC_ESTIMATE, 32'd0, 16'd0, 24'h7FFFFF);
    for (k = 0; k < 17; k++)
      add_item(tgrls_pkg::FUNC_PUSH, 32'(1000 * k),
               (k == 0) ? 16'hFFFF : 16'(1000 * k), 24'd0);
    add_item(tgrls_pkg::FUNC_ESTIMATE, 32'd36000, 16'd0, 24'h800000);
    add_item(tgrls_pkg::FUNC_ESTIMATE, 32'd37000, 16'd0, 24'h7FFFFF);
    add_item(tgrls_pkg::FUNC_ESTIMATE, 32'hFFFF_FFFF, 16'hFFFF, 24'd0);
    add_item(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 24'hFFFFFF);
    add_item(tgrls_pkg::FUNC_RESET, 32'd0, 16'd0, 24'd0);
    add_item(tgrls_pkg::FUNC_ESTIMATE, 32'd100000, 16'd0, 24'd0);
    wait_drained();

    for (k = 0; k < 8; k++) begin
      case (k)
        0: begin
          write_reg(tgrls_pkg::REG_FORGET, 24'd0);
          write_reg(tgrls_pkg::REG_INIT_G, 24'h7FFFFF);
          write_reg(tgrls_pkg::REG_INIT_P, 24'hFFFFFF);
          write_reg(tgrls_pkg::REG_MAX_AGE, 24'd1000000);
          write_reg(tgrls_pkg::REG_MIN_AGE, 24'd0);
        end
        1: begin
          write_reg(tgrls_pkg::REG_FORGET, 24'd131072);
          write_reg(tgrls_pkg::REG_INIT_G, 24'd0);
          write_reg(tgrls_pkg::REG_INIT_P, 24'd1);
          write_reg(tgrls_pkg::REG_MAX_AGE, 24'd0);
          write_reg(tgrls_pkg::REG_MIN_AGE, 24'd1000000);
        end
        2: begin
          write_reg(tgrls_pkg::REG_FORGET, 24'h3FFFF);
          write_reg(tgrls_pkg::REG_INIT_G, 24'd989086);
          write_reg(tgrls_pkg::REG_INIT_P, 24'd1000000);
          write_reg(tgrls_pkg::REG_MAX_AGE, 24'd45000);
          write_reg(tgrls_pkg::REG_MIN_AGE, 24'd35000);
        end
        3: begin
          // ages reversed: nothing usable
          write_reg(tgrls_pkg::REG_MAX_AGE, 24'd10000);
          write_reg(tgrls_pkg::REG_MIN_AGE, 24'd20000);
        end
        default: begin
          write_reg(tgrls_pkg::REG_FORGET, 24'($urandom_range(1, 131072)));
          write_reg(tgrls_pkg::REG_INIT_G, 24'($urandom_range(0, 8388607)));
          write_reg(tgrls_pkg::REG_INIT_P, 24'($urandom_range(1, 16777215)));
          write_reg(tgrls_pkg::REG_MAX_AGE, 24'($urandom_range(20000, 60000)));
          write_reg(tgrls_pkg::REG_MIN_AGE, 24'($urandom_range(0, 30000)));
        end
      endcase
      add_item(tgrls_pkg::FUNC_RESET, 32'd0, 16'd0, 24'd0);
      queue_flight(190);
      if (k == 5) begin
        // hold the sender until everything queued so far has come back
        hold_in = 1'b1;
        while (in_valid || expected_results.size() > 0) @(posedge clk);
        hold_in = 1'b0;
      end
      wait_drained();
    end

    $display("covered %0d results, %0d gain updates, %0d dropped pushes, 8 register settings",
             n_results, n_updates, n_drops);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("Verification failed");
    $finish;
  end
endmodule
